[rtl/aes_ke_pkg.sv]
// aes_ke_pkg: constants, types and byte functions of the aes key expansion block
// no dependencies; imported by the word unit, the top level and the checker
package aes_ke_pkg;

    // key and schedule geometry
    localparam int KEY_WORDS    = 4;
    localparam int ROUNDS       = 10;
    localparam int BLOCK_WORDS  = 4;
    localparam int SCHED_TOTAL  = BLOCK_WORDS * (ROUNDS + 1);
    localparam int SUB_PHASE    = 4;
    localparam int WORD_W       = 32;
    localparam int WORD_INDEX_W = 6;
    localparam int PHASE_W      = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    typedef logic [WORD_W-1:0] word_t;

    // transform select for the temp word
    typedef struct packed {
        logic rot_sub;   // rotate, substitute, add round constant
        logic sub_only;  // substitute only
    } temp_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // bytewise s-box substitution of one word
    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // multiply by x in gf(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

[rtl/aes_ke_word_unit.sv]
// aes_ke_word_unit: shared temp-word transform (rotate, s-box, round constant)
// depends on aes_ke_pkg
module aes_ke_word_unit (
    input  aes_ke_pkg::word_t     temp_in,
    input  aes_ke_pkg::temp_ctl_t ctl,
    input  logic [7:0]            rcon,
    input  aes_ke_pkg::word_t     old_word,
    output aes_ke_pkg::word_t     new_word,
    output logic [7:0]            rcon_next
);
    import aes_ke_pkg::*;

    word_t rot_word;
    word_t sub_in;
    word_t sub_out;
    word_t temp_out;

    // rotate left one byte on round boundaries
    assign rot_word = {temp_in[23:0], temp_in[31:24]};
    assign sub_in   = ctl.rot_sub ? rot_word : temp_in;
    assign sub_out  = sub_word(sub_in);

    // pick transform and fold in the round constant
    always_comb begin
        if (ctl.rot_sub) begin
            temp_out = sub_out ^ {rcon, 24'h000000};
        end else if (ctl.sub_only) begin
            temp_out = sub_out;
        end else begin
            temp_out = temp_in;
        end
    end

    assign new_word  = old_word ^ temp_out;
    assign rcon_next = gf_double(rcon);

endmodule

[rtl/aes_key_expansion_top.sv]
// aes_key_expansion_top: aes key schedule, key words in, schedule words out
// depends on aes_ke_pkg and aes_ke_word_unit
//
//  channel | direction | ports                                            | beat
//  s_      | in        | s_valid s_ready s_key_word                       | one key word
//  m_      | out       | m_valid m_ready m_round_key_word m_word_index    | one schedule word
//          |           | m_last_word                                      |
//
// each key word is echoed in the next cycle; the last key word also starts
// generation, one schedule word per cycle through the shared word unit while
// the output is not stalled; s_ready stays low while generation runs, and an
// m_ready stall freezes the sequencer. after reset the count is zero and the
// round constant is 0x01; a key word that arrives after a finished schedule
// starts a new key.
module aes_key_expansion_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aes_ke_pkg::word_t s_key_word,
    output logic              m_valid,
    input  logic              m_ready,
    output aes_ke_pkg::word_t m_round_key_word,
    output logic [aes_ke_pkg::WORD_INDEX_W-1:0] m_word_index,
    output logic              m_last_word
);
    import aes_ke_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_GEN  = 1'b1;

    localparam logic [WORD_INDEX_W-1:0] LAST_INDEX = WORD_INDEX_W'(SCHED_TOTAL - 1);
    localparam logic [WORD_INDEX_W-1:0] KEY_COUNT  = WORD_INDEX_W'(KEY_WORDS);
    localparam logic [PHASE_W-1:0]      LAST_PHASE = PHASE_W'(KEY_WORDS - 1);

    logic                    state_reg, state_next;
    logic [WORD_INDEX_W-1:0] count_reg, count_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [7:0]              rcon_reg, rcon_next;
    logic                    m_valid_reg, m_valid_next;
    word_t                   m_word_reg, m_word_next;
    logic [WORD_INDEX_W-1:0] m_index_reg, m_index_next;
    logic                    m_last_reg, m_last_next;
    word_t                   win_reg [KEY_WORDS];

    logic                    out_free;
    logic                    s_fire;
    logic                    gen_fire;
    logic                    restart;
    logic [WORD_INDEX_W-1:0] base_count;
    logic [PHASE_W-1:0]      base_phase;
    logic                    push;
    word_t                   push_word;
    temp_ctl_t               ctl;
    word_t                   gen_word;
    logic [7:0]              rcon_dbl;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_LOAD) && out_free;
    assign s_fire   = s_valid && s_ready;
    assign gen_fire = (state_reg == ST_GEN) && out_free;

    // a finished schedule restarts on the next key word
    assign restart    = (count_reg >= KEY_COUNT);
    assign base_count = restart ? '0 : count_reg;
    assign base_phase = restart ? '0 : phase_reg;

    // temp transform select from the word position
    assign ctl.rot_sub  = (phase_reg == '0);
    assign ctl.sub_only = (KEY_WORDS > 6) && (int'(phase_reg) == SUB_PHASE);

    aes_ke_word_unit u_word (
        .temp_in   (win_reg[0]),
        .ctl       (ctl),
        .rcon      (rcon_reg),
        .old_word  (win_reg[KEY_WORDS-1]),
        .new_word  (gen_word),
        .rcon_next (rcon_dbl)
    );

    assign push      = s_fire || gen_fire;
    assign push_word = s_fire ? s_key_word : gen_word;

    // sequencer and output register next state
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        rcon_next    = rcon_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_word_next  = s_key_word;
            m_index_next = base_count;
            m_last_next  = (base_count == LAST_INDEX);
            count_next   = base_count + 1'b1;
            phase_next   = (base_phase == LAST_PHASE) ? '0 : base_phase + 1'b1;
            if (restart) begin
                rcon_next = RCON_INIT;
            end
            if (base_count == KEY_COUNT - 1'b1) begin
                state_next = ST_GEN;
            end
        end else if (gen_fire) begin
            m_valid_next = 1'b1;
            m_word_next  = gen_word;
            m_index_next = count_reg;
            m_last_next  = (count_reg == LAST_INDEX);
            count_next   = count_reg + 1'b1;
            phase_next   = (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
            if (ctl.rot_sub) begin
                rcon_next = rcon_dbl;
            end
            if (count_reg == LAST_INDEX) begin
                state_next = ST_LOAD;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            phase_reg   <= '0;
            rcon_reg    <= RCON_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            rcon_reg    <= rcon_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // word window: newest in slot 0, word i-nk in the last slot
    always_ff @(posedge aclk) begin
        if (push) begin
            win_reg[0] <= push_word;
            for (int k = 1; k < KEY_WORDS; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_round_key_word = m_word_reg;
    assign m_word_index     = m_index_reg;
    assign m_last_word      = m_last_reg;

endmodule

[rtl/aes_ke_checker.sv]
// aes_ke_checker: port-level assertions for the aes key expansion top level
// depends on aes_ke_pkg; bound to aes_key_expansion_top below
module aes_ke_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input aes_ke_pkg::word_t s_key_word,
    input logic              m_valid,
    input logic              m_ready,
    input aes_ke_pkg::word_t m_round_key_word,
    input logic [aes_ke_pkg::WORD_INDEX_W-1:0] m_word_index,
    input logic              m_last_word
);
    import aes_ke_pkg::*;

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_round_key_word)
            && $stable(m_word_index) && $stable(m_last_word))
        else $error("result beat changed under stall");

    // every key word is echoed in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid && (m_round_key_word == $past(s_key_word)))
        else $error("key word not echoed");

    // last marker only on the final schedule index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == WORD_INDEX_W'(SCHED_TOTAL - 1))))
        else $error("last marker mismatch");

    // no key word taken while later schedule words are still to be generated
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready
            && (m_word_index >= WORD_INDEX_W'(KEY_WORDS - 1))
            && (m_word_index < WORD_INDEX_W'(SCHED_TOTAL - 2)) |=> !s_ready)
        else $error("input ready during generation");

endmodule

bind aes_key_expansion_top aes_ke_checker u_aes_ke_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_key_word       (s_key_word),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_round_key_word (m_round_key_word),
    .m_word_index     (m_word_index),
    .m_last_word      (m_last_word)
);
